@@ rtl/qphs_pkg.sv @@
`default_nettype none
package qphs_pkg;

	localparam int KEY_W          = 31;
	localparam int CNT_W          = 10;
	localparam int DEF_TABLE_SIZE = 1021;
	localparam int DEF_MAX_KEYS   = 510;

	typedef enum logic [1:0] {
		ST_PRESENT  = 2'd0,
		ST_INSERTED = 2'd1,
		ST_ABSENT   = 2'd2,
		ST_REFUSED  = 2'd3
	} status_t;

endpackage
`default_nettype wire

@@ rtl/qphs_ram.sv @@
`default_nettype none
module qphs_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 1021
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

@@ rtl/qphs_modadd.sv @@
`default_nettype none
// Modular add: both operands must sum to less than twice the modulus.
module qphs_modadd #(
	parameter int MOD = 1021,
	parameter int W   = 10
) (
	input  wire logic [W:0]   a,
	input  wire logic [W:0]   b,
	output logic      [W-1:0] y
);

	localparam logic [W+1:0] MOD_V = (W+2)'(MOD);

	logic [W+1:0] sum;
	logic [W+1:0] red;

	always_comb begin
		sum = {1'b0, a} + {1'b0, b};
		red = (sum >= MOD_V) ? (sum - MOD_V) : sum;
		y   = red[W-1:0];
	end

endmodule
`default_nettype wire

@@ rtl/quadratic_probe_hash_set.sv @@
`default_nettype none
// Key set held in an open-addressed table of TABLE_SIZE slots (TABLE_SIZE prime),
// probed with cumulative quadratic steps. A slot value of zero means empty.
//
// Command channel: drive op/key and raise start; the command transfers at a rising
// edge with start high and busy low. op = 0 looks up key, op = 1 inserts it. The key
// 0 always counts as present and is answered without touching the table.
//
// Result channel: done is high for exactly one cycle with status, probe_count and
// keys_held valid. The receiver cannot stall; the result is gone after that cycle.
//
// Sequence: the key is reduced modulo TABLE_SIZE by reciprocal multiply, multiply back
// and remainder correction in the shared modular adder; each probe is a table read plus a
// compare, and each collision uses the adder for the odd term, then the square, then the
// slot index. The walk also ends when it returns to home or runs out of probes; key 0 is
// answered directly. One command is in flight at a time; busy stays high until done.
//
// Reset: state, key count and max_keys (510) reset at once; then a clearing pass
// writes zero to every slot, with busy high. max_keys may be written at any time
// the block is idle, also during the clearing pass.
module quadratic_probe_hash_set #(
	parameter int TABLE_SIZE = qphs_pkg::DEF_TABLE_SIZE
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        op,
	input  wire logic [qphs_pkg::KEY_W-1:0]  key,
	input  wire logic                        max_keys_we,
	input  wire logic [qphs_pkg::CNT_W-1:0]  max_keys_wdata,
	output logic                             done,
	output logic [1:0]                       status,
	output logic [qphs_pkg::CNT_W-1:0]       probe_count,
	output logic [qphs_pkg::CNT_W-1:0]       keys_held
);

	import qphs_pkg::*;

	// Slot index width, and a collision counter wide enough for TABLE_SIZE and 1023.
	localparam int PW    = $clog2(TABLE_SIZE);
	localparam int CRAW  = $clog2(TABLE_SIZE + 1);
	localparam int CW    = (CRAW > CNT_W) ? CRAW : CNT_W;
	// Reciprocal scaling: the estimated quotient is at most one below the true one.
	localparam int SH    = KEY_W + PW;
	localparam int QW    = KEY_W + 1 - PW;

	localparam logic [CW-1:0]    C_LIMIT  = CW'(TABLE_SIZE);
	localparam logic [CW-1:0]    C_SAT    = CW'((1 << CNT_W) - 1);
	localparam logic [PW-1:0]    LAST_IDX = PW'(TABLE_SIZE - 1);
	localparam logic [KEY_W:0]   RECIP    = (KEY_W+1)'((64'd1 << SH) / 64'(TABLE_SIZE));

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RECIP,
		S_BACK,
		S_REDUCE,
		S_PROBE,
		S_CHECK,
		S_STEP_D,
		S_STEP_SQ,
		S_STEP_POS
	} state_t;

	state_t            state_q;
	logic [PW-1:0]     clr_q;
	logic              op_q;
	logic [KEY_W-1:0]  key_q;
	logic [QW-1:0]     quot_q;
	logic [PW:0]       qm_q;     // low bits of quotient * TABLE_SIZE
	logic [PW-1:0]     pos_q;
	logic [PW-1:0]     home_q;
	logic [PW-1:0]     d_q;      // 2c-1 mod TABLE_SIZE
	logic [PW-1:0]     sq_q;     // c*c mod TABLE_SIZE
	logic [CW-1:0]     c_q;
	logic [CNT_W-1:0]  stored_q;
	logic [CNT_W-1:0]  max_keys_q;
	logic              done_q;
	status_t           status_q;
	logic [CNT_W-1:0]  probe_q;
	logic [CNT_W-1:0]  held_q;

	logic [PW:0]       add_a;
	logic [PW:0]       add_b;
	logic [PW-1:0]     add_y;

	logic [2*KEY_W:0]  prod;
	logic [QW-1:0]     quot;

	logic              ram_we;
	logic [PW-1:0]     ram_waddr;
	logic [KEY_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [KEY_W-1:0]  ram_rdata;

	logic [CNT_W:0]    next_count;
	logic              room;
	logic              hit;
	logic              hole;
	logic              path_end;
	logic [CNT_W-1:0]  c_sat;

	// Quotient estimate by the scaled reciprocal of TABLE_SIZE
	always_comb begin
		prod = (2*KEY_W+1)'(key_q) * (2*KEY_W+1)'(RECIP);
		quot = QW'(prod >> SH);
	end

	// Shared modular adder: operand select by sequencer step.
	always_comb begin
		case (state_q)
			S_REDUCE: begin
				// remainder estimate lies below twice TABLE_SIZE; fold it once
				add_a = key_q[PW:0] - qm_q;
				add_b = '0;
			end
			S_STEP_D: begin
				add_a = {1'b0, d_q};
				add_b = (PW+1)'(2);
			end
			S_STEP_SQ: begin
				add_a = {1'b0, sq_q};
				add_b = {1'b0, d_q};
			end
			S_STEP_POS: begin
				add_a = {1'b0, pos_q};
				add_b = {1'b0, sq_q};
			end
			default: begin
				add_a = '0;
				add_b = '0;
			end
		endcase
	end

	qphs_modadd #(
		.MOD (TABLE_SIZE),
		.W   (PW)
	) u_add (
		.a (add_a),
		.b (add_b),
		.y (add_y)
	);

	always_comb begin
		next_count = {1'b0, stored_q} + (CNT_W+1)'(1);
		room       = next_count <= {1'b0, max_keys_q};
		hit        = ram_rdata == key_q;
		hole       = ram_rdata == '0;
		path_end   = (c_q == C_LIMIT) || ((c_q != '0) && (pos_q == home_q));
		c_sat      = (c_q > C_SAT) ? C_SAT[CNT_W-1:0] : c_q[CNT_W-1:0];
	end

	// Table write: zero sweep after reset, or placement of an inserted key.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = key_q;
		ram_re    = state_q == S_PROBE && !path_end;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_CHECK: begin
				ram_we = !hit && hole && op_q && room;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	qphs_ram #(
		.WIDTH (KEY_W),
		.DEPTH (TABLE_SIZE)
	) u_slots (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (pos_q),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			stored_q   <= '0;
			max_keys_q <= CNT_W'(DEF_MAX_KEYS);
			done_q     <= 1'b0;
			op_q       <= 1'b0;
			key_q      <= '0;
			quot_q     <= '0;
			qm_q       <= '0;
			pos_q      <= '0;
			home_q     <= '0;
			d_q        <= '0;
			sq_q       <= '0;
			c_q        <= '0;
			status_q   <= ST_PRESENT;
			probe_q    <= '0;
			held_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (max_keys_we) begin
				max_keys_q <= max_keys_wdata;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + PW'(1);
					if (clr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q  <= op;
						key_q <= key;
						pos_q <= '0;
						c_q   <= '0;
						d_q   <= LAST_IDX;
						sq_q  <= '0;
						if (key == '0) begin
							// key zero: present by definition, answer at once
							done_q   <= 1'b1;
							status_q <= ST_PRESENT;
							probe_q  <= '0;
							held_q   <= stored_q;
						end else begin
							state_q <= S_RECIP;
						end
					end
				end
				S_RECIP: begin
					quot_q  <= quot;
					state_q <= S_BACK;
				end
				S_BACK: begin
					qm_q    <= (PW+1)'(KEY_W'(quot_q) * KEY_W'(TABLE_SIZE));
					state_q <= S_REDUCE;
				end
				S_REDUCE: begin
					pos_q   <= add_y;
					home_q  <= add_y;
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (path_end) begin
						// wrapped to home or ran out of probes: no free slot
						done_q   <= 1'b1;
						status_q <= op_q ? ST_REFUSED : ST_ABSENT;
						probe_q  <= c_sat;
						held_q   <= stored_q;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (hit || hole) begin
						done_q  <= 1'b1;
						probe_q <= c_sat;
						state_q <= S_IDLE;
						if (hit) begin
							status_q <= ST_PRESENT;
							held_q   <= stored_q;
						end else if (!op_q) begin
							status_q <= ST_ABSENT;
							held_q   <= stored_q;
						end else if (room) begin
							status_q <= ST_INSERTED;
							stored_q <= next_count[CNT_W-1:0];
							held_q   <= next_count[CNT_W-1:0];
						end else begin
							status_q <= ST_REFUSED;
							held_q   <= stored_q;
						end
					end else begin
						c_q     <= c_q + CW'(1);
						state_q <= S_STEP_D;
					end
				end
				S_STEP_D: begin
					d_q     <= add_y;
					state_q <= S_STEP_SQ;
				end
				S_STEP_SQ: begin
					sq_q    <= add_y;
					state_q <= S_STEP_POS;
				end
				S_STEP_POS: begin
					pos_q   <= add_y;
					state_q <= S_PROBE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign probe_count = probe_q;
	assign keys_held   = held_q;

endmodule
`default_nettype wire
